@@ src/cda_pkg.sv @@
// shared types, constants and calendar helpers for the date adder
package cda_pkg;

    // default widths of the amount and year fields
    localparam int AMOUNT_BITS_DEF = 12;
    localparam int YEAR_BITS_DEF   = 14;

    // operation codes
    localparam logic [1:0] OP_ADD_DAYS   = 2'd0;
    localparam logic [1:0] OP_ADD_MONTHS = 2'd1;
    localparam logic [1:0] OP_ADD_YEARS  = 2'd2;
    localparam logic [1:0] OP_NEXT_MONTH = 2'd3;

    // divisors used by the shared divider
    localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;
    localparam logic [4:0] YEAR_MOD_BASE   = 5'd25;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MON,
        S_YEAR_MOD,
        S_DIV_YEAR,
        S_WALK,
        S_FINISH
    } t_state;

    // days in a month, month is 1..12
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        begin
            unique case (month)
                4'd1:    days = 5'd31;
                4'd2:    days = leap ? FEB_LEAP_DAYS : 5'd28;
                4'd3:    days = 5'd31;
                4'd4:    days = 5'd30;
                4'd5:    days = 5'd31;
                4'd6:    days = 5'd30;
                4'd7:    days = 5'd31;
                4'd8:    days = 5'd31;
                4'd9:    days = 5'd30;
                4'd10:   days = 5'd31;
                4'd11:   days = 5'd30;
                4'd12:   days = 5'd31;
                default: days = 5'd31;
            endcase
            month_days = days;
        end
    endfunction

    // leap rule from the low year bits and the year modulo 25
    // divisible by 400 is divisible by 16 and 25, by 100 is by 4 and 25
    function automatic logic is_leap(input logic [3:0] year_lo, input logic [4:0] year_mod25);
        logic leap;
        begin
            if (year_mod25 == 5'd0) begin
                leap = (year_lo == 4'd0);
            end else begin
                leap = (year_lo[1:0] == 2'd0);
            end
            is_leap = leap;
        end
    endfunction

endpackage

@@ src/cda_div.sv @@
// constant divider by twelve or twenty-five on one shared reciprocal multiplier
module cda_div #(
    parameter int W = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic         i_by_year,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [4:0]   o_rem
);

    import cda_pkg::*;

    // reciprocals rounded up, exact for every dividend below 2^W
    localparam int SH_MON  = W + 4;
    localparam int SH_YEAR = W + 5;
    localparam int RECIP_W = W + 1;
    localparam int PROD_W  = W + RECIP_W;
    localparam longint RECIP_MON_L  =
        ((longint'(1) << SH_MON) / longint'(MONTHS_PER_YEAR)) + longint'(1);
    localparam longint RECIP_YEAR_L =
        ((longint'(1) << SH_YEAR) / longint'(YEAR_MOD_BASE)) + longint'(1);
    localparam logic [RECIP_W-1:0] RECIP_MON  = RECIP_W'(RECIP_MON_L);
    localparam logic [RECIP_W-1:0] RECIP_YEAR = RECIP_W'(RECIP_YEAR_L);

    logic [W-1:0] r_num;
    logic         r_by_year;
    logic [W-1:0] r_quot, n_quot;
    logic         r_busy;
    logic         r_done;

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [4:0]         divisor;

    // one multiply by the reciprocal, then the matching shift
    always_comb begin
        recip   = r_by_year ? RECIP_YEAR : RECIP_MON;
        divisor = r_by_year ? YEAR_MOD_BASE : MONTHS_PER_YEAR;
        prod    = PROD_W'(r_num) * PROD_W'(recip);
        n_quot  = r_by_year ? W'(prod >> SH_YEAR) : W'(prod >> SH_MON);
    end

    // operand captured on start, quotient registered in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy && !i_start;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num     <= i_dividend;
            r_by_year <= i_by_year;
        end
        if (r_busy) begin
            r_quot <= n_quot;
        end
    end

    // remainder is below 32, so the low five bits are enough
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_num[4:0] - (r_quot[4:0] * divisor);

endmodule

@@ src/calendar_date_adder.sv @@
// gregorian date adder top level: sequencer, month walk and result register
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+-------------------------------------------------
//  input    | i_valid | o_stall | i_op, i_start_day, i_start_month, i_start_year,
//           |         |         | i_amount
//  output   | o_valid | i_stall | o_res_day, o_res_month, o_res_year,
//           |         |         | o_year_overflow, o_bad_input
//
// one transaction at a time; o_stall is high from acceptance until the result is loaded.
// add years, next month and bad input go straight to the finish step; add days runs the year
// modulo 25 and the month walk first; add months also divides by twelve and needs at most one month step.
// the month walk sets the worst case: 4126 days is about 136 months.
// synchronous active-low reset; a stalled result holds and the finish step waits for it.
module calendar_date_adder #(
    parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_op,
    input  logic [4:0]             i_start_day,
    input  logic [3:0]             i_start_month,
    input  logic [YEAR_BITS-1:0]   i_start_year,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [4:0]             o_res_day,
    output logic [3:0]             o_res_month,
    output logic [YEAR_BITS-1:0]   o_res_year,
    output logic                   o_year_overflow,
    output logic                   o_bad_input
);

    import cda_pkg::*;

    localparam int DIV_W = (AMOUNT_BITS + 1 > YEAR_BITS) ? AMOUNT_BITS + 1 : YEAR_BITS;
    localparam int SUM_W = DIV_W + 1;
    localparam int DAY_W = ((AMOUNT_BITS > 5) ? AMOUNT_BITS : 5) + 1;
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

    t_state r_state, n_state;

    logic [DAY_W-1:0]     r_d, n_d;
    logic [3:0]           r_m, n_m;
    logic [YEAR_BITS-1:0] r_y, n_y;
    logic [4:0]           r_r25, n_r25;
    logic                 r_ovf, n_ovf;
    logic                 r_bad, n_bad;

    logic                 r_ovalid, n_ovalid;
    logic [4:0]           r_res_day, n_res_day;
    logic [3:0]           r_res_month, n_res_month;
    logic [YEAR_BITS-1:0] r_res_year, n_res_year;
    logic                 r_res_ovf, n_res_ovf;
    logic                 r_res_bad, n_res_bad;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_by_year;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [4:0]       div_rem;

    logic             accept;
    logic             in_bad;
    logic [SUM_W-1:0] year_sum;
    logic [SUM_W-1:0] amt_sum;
    logic [DIV_W-1:0] month_index;
    logic [4:0]       cur_days;
    logic             out_free;

    // shared reciprocal divider, by 12 for months and by 25 for the leap rule
    cda_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_by_year  (div_by_year),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // shared helpers
    always_comb begin
        accept      = i_valid && (r_state == S_IDLE);
        in_bad      = (i_start_month < MONTH_FIRST) || (i_start_month > MONTH_LAST)
                      || (i_start_day == 5'd0);
        month_index = DIV_W'(i_start_month) - DIV_W'(1) + DIV_W'(i_amount);
        amt_sum     = SUM_W'(i_start_year) + SUM_W'(i_amount);
        year_sum    = SUM_W'(r_y) + SUM_W'(div_quot);
        cur_days    = month_days(r_m, is_leap(r_y[3:0], r_r25));
        out_free    = !r_ovalid || !i_stall;
    end

    // sequencer and month walk
    always_comb begin
        n_state      = r_state;
        n_d          = r_d;
        n_m          = r_m;
        n_y          = r_y;
        n_r25        = r_r25;
        n_ovf        = r_ovf;
        n_bad        = r_bad;
        div_start    = 1'b0;
        div_dividend = DIV_W'(r_y);
        div_by_year  = 1'b1;

        n_ovalid     = r_ovalid && i_stall;
        n_res_day    = r_res_day;
        n_res_month  = r_res_month;
        n_res_year   = r_res_year;
        n_res_ovf    = r_res_ovf;
        n_res_bad    = r_res_bad;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_d   = DAY_W'(i_start_day);
                    n_m   = i_start_month;
                    n_y   = i_start_year;
                    n_ovf = 1'b0;
                    n_bad = in_bad;
                    if (in_bad) begin
                        n_d     = DAY_W'(1);
                        n_m     = MONTH_FIRST;
                        n_state = S_FINISH;
                    end else begin
                        unique case (i_op)
                            OP_ADD_DAYS: begin
                                n_d     = DAY_W'(i_start_day) + DAY_W'(i_amount);
                                n_state = S_YEAR_MOD;
                            end
                            OP_ADD_MONTHS: begin
                                div_start    = 1'b1;
                                div_dividend = month_index;
                                div_by_year  = 1'b0;
                                n_state      = S_DIV_MON;
                            end
                            OP_ADD_YEARS: begin
                                if (amt_sum[SUM_W-1:YEAR_BITS] != '0) begin
                                    n_y   = YEAR_MAX;
                                    n_ovf = 1'b1;
                                end else begin
                                    n_y = amt_sum[YEAR_BITS-1:0];
                                end
                                n_state = S_FINISH;
                            end
                            OP_NEXT_MONTH: begin
                                if (i_start_month == MONTH_LAST) begin
                                    n_m = MONTH_FIRST;
                                    if (i_start_year == YEAR_MAX) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_y = i_start_year + 1'b1;
                                    end
                                end else begin
                                    n_m = i_start_month + 1'b1;
                                end
                                n_state = S_FINISH;
                            end
                            default: n_state = S_FINISH;
                        endcase
                    end
                end
            end
            // months: quotient goes to the year, remainder plus one is the new month
            S_DIV_MON: begin
                if (div_done) begin
                    n_m = div_rem[3:0] + 1'b1;
                    if (year_sum[SUM_W-1:YEAR_BITS] != '0) begin
                        n_y   = YEAR_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_y = year_sum[YEAR_BITS-1:0];
                    end
                    n_state = S_YEAR_MOD;
                end
            end
            // current year modulo 25 for the leap rule
            S_YEAR_MOD: begin
                div_start = 1'b1;
                n_state   = S_DIV_YEAR;
            end
            S_DIV_YEAR: begin
                if (div_done) begin
                    n_r25   = div_rem;
                    n_state = S_WALK;
                end
            end
            // one month per cycle while the day is past the month end
            S_WALK: begin
                if (r_d > DAY_W'(cur_days)) begin
                    n_d = r_d - DAY_W'(cur_days);
                    if (r_m == MONTH_LAST) begin
                        n_m = MONTH_FIRST;
                        if (r_y == YEAR_MAX) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_y   = r_y + 1'b1;
                            n_r25 = (r_r25 == YEAR_MOD_BASE - 5'd1) ? 5'd0 : r_r25 + 5'd1;
                        end
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            // load the result register once it is free
            S_FINISH: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_res_day   = r_d[4:0];
                    n_res_month = r_m;
                    n_res_year  = r_y;
                    n_res_ovf   = r_ovf;
                    n_res_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_d         <= n_d;
        r_m         <= n_m;
        r_y         <= n_y;
        r_r25       <= n_r25;
        r_ovf       <= n_ovf;
        r_bad       <= n_bad;
        r_res_day   <= n_res_day;
        r_res_month <= n_res_month;
        r_res_year  <= n_res_year;
        r_res_ovf   <= n_res_ovf;
        r_res_bad   <= n_res_bad;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_res_day       = r_res_day;
    assign o_res_month     = r_res_month;
    assign o_res_year      = r_res_year;
    assign o_year_overflow = r_res_ovf;
    assign o_bad_input     = r_res_bad;

endmodule

@@ verif/calendar_date_adder_check.sv @@
// scoreboard for the date adder: predicts each result date and compares it field by field
module calendar_date_adder_check #(
    parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [1:0]             i_op,
    input  logic [4:0]             i_start_day,
    input  logic [3:0]             i_start_month,
    input  logic [YEAR_BITS-1:0]   i_start_year,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [4:0]             i_res_day,
    input  logic [3:0]             i_res_month,
    input  logic [YEAR_BITS-1:0]   i_res_year,
    input  logic                   i_year_overflow,
    input  logic                   i_bad_input,
    output int                     o_fail_count,
    output int                     o_dates_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cda_pkg::*;

    localparam int unsigned YEAR_MAX = (1 << YEAR_BITS) - 1;

    typedef struct packed {
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
        logic                 ovf;
        logic                 bad;
    } t_date;

    t_date dates_due[$];
    t_date due;
    int    fail_total = 0;
    int    open_total = 0;

    assign o_fail_count    = fail_total;
    assign o_dates_pending = open_total;

    // gregorian rule: every 4th year, but not centuries unless divisible by 400
    function automatic bit leap_year(input int unsigned year);
        return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned month,
                                                 input int unsigned year);
        case (month)
            2: begin
                return leap_year(year) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    // resulting date for one request
    function automatic t_date add_to_date(input logic [1:0]             op,
                                          input logic [4:0]             day_in,
                                          input logic [3:0]             month_in,
                                          input logic [YEAR_BITS-1:0]   year_in,
                                          input logic [AMOUNT_BITS-1:0] amount);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned month_idx;
        bit          ovf;
        bit          bad;
        t_date       res;
        day   = 32'(day_in);
        month = 32'(month_in);
        year  = 32'(year_in);
        ovf   = 1'b0;
        bad   = (month < 1) || (month > 12) || (day == 0);
        if (bad) begin
            day   = 1;
            month = 1;
        end else begin
            case (op)
                OP_ADD_DAYS: begin
                    day += 32'(amount);
                end
                OP_ADD_MONTHS: begin
                    month_idx = month - 1 + 32'(amount);
                    month     = month_idx % 12 + 1;
                    year     += month_idx / 12;
                end
                OP_ADD_YEARS: begin
                    year += 32'(amount);
                end
                default: begin
                    month += 1;
                    if (month > 12) begin
                        month = 1;
                        year += 1;
                    end
                end
            endcase
            if (year > YEAR_MAX) begin
                year = YEAR_MAX;
                ovf  = 1'b1;
            end
            // days past the month end roll into the following months
            if (op == OP_ADD_DAYS || op == OP_ADD_MONTHS) begin
                while (day > month_length(month, year)) begin
                    day   -= month_length(month, year);
                    month += 1;
                    if (month > 12) begin
                        month = 1;
                        if (year == YEAR_MAX) begin
                            ovf = 1'b1;
                        end else begin
                            year += 1;
                        end
                    end
                end
            end
        end
        res.day   = day[4:0];
        res.month = month[3:0];
        res.year  = year[YEAR_BITS-1:0];
        res.ovf   = ovf;
        res.bad   = bad;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_total++;
        end
    endtask

    // record accepted requests, then match returned dates in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                dates_due.push_back(add_to_date(i_op, i_start_day, i_start_month,
                                                i_start_year, i_amount));
            end
            if (i_out_valid && !i_out_stall) begin
                if (dates_due.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_total++;
                end else begin
                    due = dates_due.pop_front();
                    compare_field("res_day", 32'(due.day), 32'(i_res_day));
                    compare_field("res_month", 32'(due.month), 32'(i_res_month));
                    compare_field("res_year", 32'(due.year), 32'(i_res_year));
                    compare_field("year_overflow", 32'(due.ovf), 32'(i_year_overflow));
                    compare_field("bad_input", 32'(due.bad), 32'(i_bad_input));
                end
            end
            open_total = dates_due.size();
        end
    end

endmodule

@@ verif/calendar_date_adder_test.sv @@
// testbench top for the date adder: clock, reset, stimulus phases and verdict
module calendar_date_adder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cda_pkg::*;

    localparam int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF;
    localparam int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF;
    localparam logic [YEAR_BITS-1:0]   YEAR_MAX   = '1;
    localparam logic [AMOUNT_BITS-1:0] AMOUNT_MAX = '1;
    localparam int RANDOM_PER_PHASE = 238;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   i_stall       = 1'b0;
    logic [1:0]             i_op          = OP_ADD_DAYS;
    logic [4:0]             i_start_day   = '0;
    logic [3:0]             i_start_month = '0;
    logic [YEAR_BITS-1:0]   i_start_year  = '0;
    logic [AMOUNT_BITS-1:0] i_amount      = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic [4:0]             o_res_day;
    logic [3:0]             o_res_month;
    logic [YEAR_BITS-1:0]   o_res_year;
    logic                   o_year_overflow;
    logic                   o_bad_input;

    int fail_count;
    int dates_pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    int phase_idle[4]  = '{0, 73, 0, 33};
    int phase_stall[4] = '{0, 0, 73, 33};

    calendar_date_adder #(
        .AMOUNT_BITS(AMOUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_dut (.*);

    calendar_date_adder_check #(
        .AMOUNT_BITS(AMOUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_op           (i_op),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_amount       (i_amount),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_res_day      (o_res_day),
        .i_res_month    (o_res_month),
        .i_res_year     (o_res_year),
        .i_year_overflow(o_year_overflow),
        .i_bad_input    (o_bad_input),
        .o_fail_count   (fail_count),
        .o_dates_pending(dates_pending)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("calendar_date_adder: mismatch");
        $finish;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send_date(input logic [1:0]             op,
                             input logic [4:0]             day,
                             input logic [3:0]             month,
                             input logic [YEAR_BITS-1:0]   year,
                             input logic [AMOUNT_BITS-1:0] amount);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_start_day   <= day;
        i_start_month <= month;
        i_start_year  <= year;
        i_amount      <= amount;
        // inputs settle by the falling edge, so o_stall there holds for the next rise
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // stop sending until every outstanding date has come back
    task automatic drain_dates();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (dates_pending != 0);
        @(posedge i_clk);
    endtask

    // mostly well-formed dates with short amounts, some long walks and some noise
    task automatic send_random_date();
        int unsigned            pick;
        logic [1:0]             op;
        logic [4:0]             day;
        logic [3:0]             month;
        logic [YEAR_BITS-1:0]   year;
        logic [AMOUNT_BITS-1:0] amount;
        pick   = $urandom_range(99);
        op     = 2'($urandom_range(3));
        day    = 5'($urandom);
        month  = 4'($urandom);
        year   = YEAR_BITS'($urandom);
        amount = AMOUNT_BITS'($urandom);
        if (pick >= 12) begin
            month = 4'($urandom_range(1, 12));
            day   = (pick < 30) ? 5'($urandom_range(1, 31)) : 5'($urandom_range(1, 28));
            case ($urandom_range(3))
                0: begin
                end
                1: begin
                    year = YEAR_MAX - YEAR_BITS'($urandom_range(0, 20));
                end
                2: begin
                    year = YEAR_BITS'($urandom_range(0, 163) * 100 + $urandom_range(0, 4));
                end
                default: begin
                    year = YEAR_BITS'($urandom_range(0, 30));
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 75) begin
                amount = AMOUNT_BITS'($urandom_range(0, 70));
            end else if (pick < 88) begin
                amount = AMOUNT_MAX - AMOUNT_BITS'($urandom_range(0, 15));
            end
        end
        send_date(op, day, month, year, amount);
    endtask

    // reset, directed cases, random phases, verdict
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and calendar corner cases
        send_date(OP_ADD_DAYS, 5'd1, 4'd1, 14'd2000, 12'd0);
        send_date(OP_ADD_DAYS, 5'd31, 4'd12, YEAR_MAX, 12'd1);
        send_date(OP_ADD_DAYS, 5'd1, 4'd1, 14'd0, AMOUNT_MAX);
        send_date(OP_ADD_DAYS, 5'd28, 4'd2, 14'd1900, 12'd1);
        send_date(OP_ADD_DAYS, 5'd28, 4'd2, 14'd2000, 12'd1);
        send_date(OP_ADD_DAYS, 5'd28, 4'd2, 14'd2024, 12'd1);
        send_date(OP_ADD_DAYS, 5'd28, 4'd2, 14'd0, 12'd1);
        send_date(OP_ADD_DAYS, 5'd31, 4'd2, 14'd2023, 12'd0);
        send_date(OP_ADD_DAYS, 5'd30, 4'd11, YEAR_MAX, AMOUNT_MAX);
        send_date(OP_ADD_MONTHS, 5'd31, 4'd1, 14'd2023, 12'd1);
        send_date(OP_ADD_MONTHS, 5'd31, 4'd1, 14'd2024, 12'd1);
        send_date(OP_ADD_MONTHS, 5'd31, 4'd4, 14'd100, 12'd0);
        send_date(OP_ADD_MONTHS, 5'd12, 4'd12, YEAR_MAX, AMOUNT_MAX);
        send_date(OP_ADD_MONTHS, 5'd31, 4'd12, YEAR_MAX, 12'd1);
        send_date(OP_ADD_YEARS, 5'd29, 4'd2, 14'd16000, AMOUNT_MAX);
        send_date(OP_ADD_YEARS, 5'd31, 4'd2, 14'd1999, 12'd0);
        send_date(OP_ADD_YEARS, 5'd29, 4'd2, 14'd2000, 12'd1);
        send_date(OP_NEXT_MONTH, 5'd12, 4'd12, YEAR_MAX, 12'd0);
        send_date(OP_NEXT_MONTH, 5'd31, 4'd1, 14'd2023, AMOUNT_MAX);
        send_date(OP_ADD_DAYS, 5'd15, 4'd0, 14'd500, 12'd10);
        send_date(OP_ADD_MONTHS, 5'd15, 4'd13, 14'd500, 12'd10);
        send_date(OP_ADD_YEARS, 5'd0, 4'd6, 14'd500, 12'd10);
        send_date(OP_NEXT_MONTH, 5'd31, 4'd15, YEAR_MAX, AMOUNT_MAX);
        send_date(OP_ADD_DAYS, 5'd0, 4'd0, 14'd0, 12'd0);
        drain_dates();

        // random traffic under each idle and stall mix
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = phase_idle[phase];
            stall_pct = phase_stall[phase];
            repeat (RANDOM_PER_PHASE) send_random_date();
            drain_dates();
        end

        // let any stray result show up before the verdict
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && dates_pending == 0) begin
            $display("calendar_date_adder: match");
        end else begin
            $display("calendar_date_adder: mismatch");
        end
        $finish;
    end

endmodule
